[rtl/rci_pkg.sv]
// Shared types, widths and helpers for the ray/cone intersection block.
// Used by rci_iter, rci_front, rci_back and ray_cone_intersect.
// No dependencies.
`default_nettype none
package rci_pkg;

   localparam int FRAC_BITS = 16;
   localparam int CW        = 32;                     // coordinate width
   localparam int PRW       = 2 * CW;                 // full product width
   localparam int SHW       = PRW - FRAC_BITS;        // product after fraction shift
   localparam int AW        = SHW + 2;                // signed width of a, h, c
   localparam int MW        = AW - 1;                 // magnitude of a, h, c
   localparam int HW        = (MW + 1) / 2;           // low half of a split operand
   localparam int PW        = 2 * MW;                 // squared magnitude
   localparam int RW        = PW + 2;                 // radicand width (even)
   localparam int QW        = RW / 2;                 // root width
   localparam int NW        = QW + 2;                 // signed root numerator
   localparam int NMW       = NW - 1;                 // numerator magnitude
   localparam int DVW       = NMW + FRAC_BITS;        // dividend width
   localparam int ITW       = QW + 3;                 // partial remainder width
   localparam int CNTW      = $clog2(DVW + 1);
   localparam int PSW       = SHW + 1;                // unsaturated point width
   localparam int TW        = 31;
   localparam int PZW       = 17;
   localparam int NRW       = 16;
   localparam int MDW       = 17;
   localparam int MXW       = CW + 14;
   localparam int QDEPTH    = 4;
   localparam int QAW       = 2;

   localparam logic [CNTW-1:0] DIV_STEPS  = DVW[CNTW-1:0];
   localparam logic [CNTW-1:0] SQRT_STEPS = QW[CNTW-1:0];
   localparam logic [TW-1:0]   T_MAX      = '1;
   localparam logic [13:0]     INV_SQRT2  = 14'd11585;
   localparam logic signed [NRW-1:0] NORM_APEX = -16'sd16384;
   localparam logic signed [NRW-1:0] NORM_Z    = -16'sd11585;
   localparam logic [MDW-1:0]  MIN_DIST_RESET = 17'd655;
   localparam logic signed [PSW-1:0] PZ_ONE =
      {{(PSW - FRAC_BITS - 1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

   typedef struct packed {
      logic signed [CW-1:0] ox;
      logic signed [CW-1:0] oy;
      logic signed [CW-1:0] oz;
      logic signed [CW-1:0] dx;
      logic signed [CW-1:0] dy;
      logic signed [CW-1:0] dz;
   } ray_type;

   typedef struct packed {
      ray_type              ray;
      logic signed [AW-1:0] a;
      logic signed [AW-1:0] h;
      logic signed [AW-1:0] c;
   } job_type;

   typedef struct packed {
      logic                  hit_found;
      logic [TW-1:0]         hit_distance;
      logic signed [CW-1:0]  point_x;
      logic signed [CW-1:0]  point_y;
      logic [PZW-1:0]        point_z;
      logic signed [NRW-1:0] normal_x;
      logic signed [NRW-1:0] normal_y;
      logic signed [NRW-1:0] normal_z;
      logic                  last_result;
   } result_type;

   typedef enum logic {ITER_SQRT, ITER_DIV} iter_op_type;

   typedef struct packed {
      logic        start;
      iter_op_type op;
   } iter_req_type;

   typedef enum logic [4:0] {
      BK_IDLE, BK_MUL, BK_DISC, BK_SQ_GO, BK_SQ_WAIT, BK_ROOT, BK_DV_GO, BK_DV_WAIT,
      BK_TEST, BK_PMUL, BK_POINT, BK_RMUL, BK_R_GO, BK_R_WAIT, BK_NX_GO, BK_NX_WAIT,
      BK_NY_GO, BK_NY_WAIT, BK_HIT, BK_NEXT, BK_FINISH
   } back_state_type;

   // floor shift of a full product
   function automatic logic signed [SHW-1:0] fshr(input logic signed [PRW-1:0] x);
      logic signed [PRW-1:0] s;
      s = x >>> FRAC_BITS;
      return $signed(s[SHW-1:0]);
   endfunction

   function automatic logic signed [AW-1:0] sum3(input logic signed [SHW-1:0] p,
                                                 input logic signed [SHW-1:0] q,
                                                 input logic signed [SHW-1:0] r);
      logic signed [AW-1:0] pe, qe, re;
      pe = {{(AW - SHW){p[SHW-1]}}, p};
      qe = {{(AW - SHW){q[SHW-1]}}, q};
      re = {{(AW - SHW){r[SHW-1]}}, r};
      return pe + qe - re;
   endfunction

   function automatic logic [MW-1:0] mag(input logic signed [AW-1:0] x);
      logic [AW-1:0] u;
      u = x[AW-1] ? -x : x;
      return u[MW-1:0];
   endfunction

   function automatic logic signed [CW-1:0] sat32(input logic signed [PSW-1:0] v);
      logic same;
      same = (&v[PSW-1:CW-1]) | ~(|v[PSW-1:CW-1]);
      if (same) begin
         return $signed(v[CW-1:0]);
      end
      return v[PSW-1] ? {1'b1, {(CW - 1){1'b0}}} : {1'b0, {(CW - 1){1'b1}}};
   endfunction

endpackage
`default_nettype wire

[rtl/rci_iter.sv]
// Shared bit-serial unit: restoring square root (two radicand bits a step)
// and restoring division (one dividend bit a step). Depends on rci_pkg.
`default_nettype none
module rci_iter (
   input  logic                        clock,
   input  logic                        reset,
   input  rci_pkg::iter_req_type       req,
   input  logic [rci_pkg::RW-1:0]      radicand,
   input  logic [rci_pkg::DVW-1:0]     dividend,
   input  logic [rci_pkg::MW-1:0]      divisor,
   output logic                        done,
   output logic [rci_pkg::DVW-1:0]     result
);

   logic                          busy_ff;
   logic                          done_ff;
   logic [rci_pkg::CNTW-1:0]      cnt_ff;
   rci_pkg::iter_op_type          op_ff;
   logic [rci_pkg::ITW-1:0]       rem_ff, rem_in;
   logic [rci_pkg::RW-1:0]        work_ff, work_in;
   logic [rci_pkg::DVW-1:0]       res_ff;
   logic [rci_pkg::MW-1:0]        dvs_ff;
   logic [rci_pkg::ITW-1:0]       sq_rem, sq_try, dv_rem, dv_try;
   logic                          ge;

   always_comb begin
      sq_rem = {rem_ff[rci_pkg::ITW-3:0], work_ff[rci_pkg::RW-1 -: 2]};
      sq_try = {res_ff[rci_pkg::ITW-3:0], 2'b01};
      dv_rem = {rem_ff[rci_pkg::ITW-2:0], work_ff[rci_pkg::RW-1]};
      dv_try = {{(rci_pkg::ITW - rci_pkg::MW){1'b0}}, dvs_ff};
      unique case (op_ff)
         rci_pkg::ITER_SQRT: begin
            ge      = sq_rem >= sq_try;
            rem_in  = ge ? sq_rem - sq_try : sq_rem;
            work_in = work_ff << 2;
         end
         rci_pkg::ITER_DIV: begin
            ge      = dv_rem >= dv_try;
            rem_in  = ge ? dv_rem - dv_try : dv_rem;
            work_in = work_ff << 1;
         end
         default: begin
            ge      = 1'b0;
            rem_in  = rem_ff;
            work_in = work_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == 1);
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= (req.op == rci_pkg::ITER_DIV) ? rci_pkg::DIV_STEPS
                                                     : rci_pkg::SQRT_STEPS;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == 1) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         op_ff   <= req.op;
         rem_ff  <= '0;
         res_ff  <= '0;
         dvs_ff  <= divisor;
         work_ff <= (req.op == rci_pkg::ITER_DIV)
                    ? {dividend, {(rci_pkg::RW - rci_pkg::DVW){1'b0}}} : radicand;
      end else if (busy_ff) begin
         rem_ff  <= rem_in;
         work_ff <= work_in;
         res_ff  <= {res_ff[rci_pkg::DVW-2:0], ge};
      end
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule
`default_nettype wire

[rtl/rci_front.sv]
// Front end: accepts rays, forms the quadratic coefficients a, h, c in one
// product stage and queues them for the back end. Depends on rci_pkg.
`default_nettype none
module rci_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  rci_pkg::ray_type  req_ray,
   input  logic              job_pop,
   output logic              job_valid,
   output rci_pkg::job_type  job
);

   logic                              take;
   logic                              s1_valid_ff;
   rci_pkg::ray_type                  s1_ray_ff;
   logic signed [rci_pkg::PRW-1:0]    dxx_ff, dyy_ff, dzz_ff;
   logic signed [rci_pkg::PRW-1:0]    oxd_ff, oyd_ff, ozd_ff;
   logic signed [rci_pkg::PRW-1:0]    oxx_ff, oyy_ff, ozz_ff;
   rci_pkg::job_type                  job_in;
   rci_pkg::job_type                  q_mem [rci_pkg::QDEPTH];
   logic [rci_pkg::QAW-1:0]           wr_ptr_ff, rd_ptr_ff;
   logic [rci_pkg::QAW:0]             cnt_ff;
   logic [rci_pkg::QAW+1:0]           fill;
   logic                              pop;

   // count transactions still in the product stage against the queue room
   assign fill = {1'b0, cnt_ff} + {{(rci_pkg::QAW + 1){1'b0}}, s1_valid_ff};
   assign busy = fill >= rci_pkg::QDEPTH;
   assign take = start && !busy;
   assign pop  = job_pop && (cnt_ff != 0);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= take;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_ray_ff <= req_ray;
         dxx_ff    <= req_ray.dx * req_ray.dx;
         dyy_ff    <= req_ray.dy * req_ray.dy;
         dzz_ff    <= req_ray.dz * req_ray.dz;
         oxd_ff    <= req_ray.ox * req_ray.dx;
         oyd_ff    <= req_ray.oy * req_ray.dy;
         ozd_ff    <= req_ray.oz * req_ray.dz;
         oxx_ff    <= req_ray.ox * req_ray.ox;
         oyy_ff    <= req_ray.oy * req_ray.oy;
         ozz_ff    <= req_ray.oz * req_ray.oz;
      end
   end

   always_comb begin
      job_in.ray = s1_ray_ff;
      job_in.a   = rci_pkg::sum3(rci_pkg::fshr(dxx_ff), rci_pkg::fshr(dyy_ff),
                                 rci_pkg::fshr(dzz_ff));
      job_in.h   = rci_pkg::sum3(rci_pkg::fshr(oxd_ff), rci_pkg::fshr(oyd_ff),
                                 rci_pkg::fshr(ozd_ff));
      job_in.c   = rci_pkg::sum3(rci_pkg::fshr(oxx_ff), rci_pkg::fshr(oyy_ff),
                                 rci_pkg::fshr(ozz_ff));
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         q_mem[wr_ptr_ff] <= job_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (s1_valid_ff) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         cnt_ff <= cnt_ff + {{rci_pkg::QAW{1'b0}}, s1_valid_ff}
                          - {{rci_pkg::QAW{1'b0}}, pop};
      end
   end

   assign job_valid = cnt_ff != 0;
   assign job       = q_mem[rd_ptr_ff];

endmodule
`default_nettype wire

[rtl/rci_back.sv]
// Back end: solves the quadratic for one queued ray at a time, tests both
// roots and issues the results. Depends on rci_pkg and rci_iter.
`default_nettype none
module rci_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [rci_pkg::MDW-1:0]   min_distance,
   input  logic                      job_valid,
   input  rci_pkg::job_type          job,
   output logic                      job_pop,
   output rci_pkg::result_type       rsp,
   output logic                      rsp_valid
);

   rci_pkg::back_state_type          state_ff, state_in;
   rci_pkg::job_type                 job_ff;
   logic [2:0]                       mul_cnt_ff;
   logic [rci_pkg::PW-1:0]           hh_ff, ac_ff;
   logic [rci_pkg::RW-1:0]           disc_ff;
   logic [rci_pkg::QW-1:0]           s_ff;
   logic [rci_pkg::NMW-1:0]          num_mag_ff;
   logic                             neg_ff, k_ff, apex_ff;
   logic [rci_pkg::TW-1:0]           t_ff;
   logic signed [rci_pkg::PRW-1:0]   prx_ff, pry_ff, prz_ff;
   logic signed [rci_pkg::CW-1:0]    px_ff, py_ff;
   logic [rci_pkg::PZW-1:0]          pz_ff;
   logic [rci_pkg::PRW-1:0]          sqx_ff, sqy_ff;
   logic [rci_pkg::MXW-1:0]          mx_ff, my_ff;
   logic [rci_pkg::CW-1:0]           r_ff;
   logic signed [rci_pkg::NRW-1:0]   nx_ff, ny_ff;
   rci_pkg::result_type              pend_ff, rsp_ff, hit, last_rsp;
   logic                             pend_valid_ff, rsp_valid_ff;

   rci_pkg::iter_req_type            iter_req;
   logic [rci_pkg::RW-1:0]           it_rad;
   logic [rci_pkg::DVW-1:0]          it_dvd;
   logic [rci_pkg::MW-1:0]           it_dvs;
   logic                             it_done;
   logic [rci_pkg::DVW-1:0]          it_res;

   logic [rci_pkg::MW-1:0]           a_mag, h_mag, c_mag, mop_x, mop_y;
   logic [rci_pkg::HW-1:0]           part_x, part_y;
   logic [2*rci_pkg::HW-1:0]         pp;
   logic [rci_pkg::PW-1:0]           pp_ext, pp_sh, acc_in;
   logic                             ac_pos, a_zero, disc_ok;
   logic [rci_pkg::RW-1:0]           hh_e, ac_e, disc_in;
   logic signed [rci_pkg::NW-1:0]    h_e, s_e, num;
   logic [rci_pkg::NW-1:0]           num_abs;
   logic [rci_pkg::TW-1:0]           t_in;
   logic                             reject;
   logic signed [rci_pkg::SHW-1:0]   shx, shy, shz;
   logic signed [rci_pkg::PSW-1:0]   sumx, sumy, sumz;
   logic signed [rci_pkg::CW-1:0]    px_in, py_in;
   logic                             z_bad, apex;
   logic [rci_pkg::PRW:0]            sq_sum;
   logic [rci_pkg::CW-1:0]           pxa, pya;
   logic [rci_pkg::NRW-1:0]          q_in;

   rci_iter u_iter (
      .clock    (clock),
      .reset    (reset),
      .req      (iter_req),
      .radicand (it_rad),
      .dividend (it_dvd),
      .divisor  (it_dvs),
      .done     (it_done),
      .result   (it_res)
   );

   // ---- datapath terms ----
   always_comb begin
      a_mag  = rci_pkg::mag(job_ff.a);
      h_mag  = rci_pkg::mag(job_ff.h);
      c_mag  = rci_pkg::mag(job_ff.c);
      mop_x  = mul_cnt_ff[2] ? a_mag : h_mag;
      mop_y  = mul_cnt_ff[2] ? c_mag : h_mag;
      part_x = mul_cnt_ff[1] ? {1'b0, mop_x[rci_pkg::MW-1:rci_pkg::HW]}
                             : mop_x[rci_pkg::HW-1:0];
      part_y = mul_cnt_ff[0] ? {1'b0, mop_y[rci_pkg::MW-1:rci_pkg::HW]}
                             : mop_y[rci_pkg::HW-1:0];
      pp     = part_x * part_y;
      pp_ext = {{(rci_pkg::PW - 2*rci_pkg::HW){1'b0}}, pp};
      unique case (mul_cnt_ff[1:0])
         2'd0:    pp_sh = pp_ext;
         2'd3:    pp_sh = pp_ext << (2*rci_pkg::HW);
         default: pp_sh = pp_ext << rci_pkg::HW;
      endcase
      acc_in = pp_sh + ((mul_cnt_ff[1:0] == 2'd0) ? '0
                        : (mul_cnt_ff[2] ? ac_ff : hh_ff));

      a_zero  = job_ff.a == 0;
      ac_pos  = !a_zero && (job_ff.c != 0) && (job_ff.a[rci_pkg::AW-1] ==
                                               job_ff.c[rci_pkg::AW-1]);
      disc_ok = !a_zero && !(ac_pos && (ac_ff > hh_ff));
      hh_e    = {2'b00, hh_ff};
      ac_e    = {2'b00, ac_ff};
      disc_in = ac_pos ? hh_e - ac_e : hh_e + ac_e;

      h_e     = {{(rci_pkg::NW - rci_pkg::AW){job_ff.h[rci_pkg::AW-1]}}, job_ff.h};
      s_e     = {2'b00, s_ff};
      num     = k_ff ? s_e - h_e : -h_e - s_e;
      num_abs = num[rci_pkg::NW-1] ? -num : num;

      t_in    = (it_res > {{(rci_pkg::DVW - rci_pkg::TW){1'b0}}, rci_pkg::T_MAX})
                ? rci_pkg::T_MAX : it_res[rci_pkg::TW-1:0];
      reject  = (t_ff == 0) || neg_ff ||
                (t_ff <= {{(rci_pkg::TW - rci_pkg::MDW){1'b0}}, min_distance});

      shx   = rci_pkg::fshr(prx_ff);
      shy   = rci_pkg::fshr(pry_ff);
      shz   = rci_pkg::fshr(prz_ff);
      sumx  = {{(rci_pkg::PSW - rci_pkg::CW){job_ff.ray.ox[rci_pkg::CW-1]}}, job_ff.ray.ox}
              + {shx[rci_pkg::SHW-1], shx};
      sumy  = {{(rci_pkg::PSW - rci_pkg::CW){job_ff.ray.oy[rci_pkg::CW-1]}}, job_ff.ray.oy}
              + {shy[rci_pkg::SHW-1], shy};
      sumz  = {{(rci_pkg::PSW - rci_pkg::CW){job_ff.ray.oz[rci_pkg::CW-1]}}, job_ff.ray.oz}
              + {shz[rci_pkg::SHW-1], shz};
      px_in = rci_pkg::sat32(sumx);
      py_in = rci_pkg::sat32(sumy);
      z_bad = sumz[rci_pkg::PSW-1] || (sumz > rci_pkg::PZ_ONE);
      apex  = (px_in == 0) && (py_in == 0);

      sq_sum = {1'b0, sqx_ff} + {1'b0, sqy_ff};
      pxa    = px_ff[rci_pkg::CW-1] ? -px_ff : px_ff;
      pya    = py_ff[rci_pkg::CW-1] ? -py_ff : py_ff;
      q_in   = it_res[rci_pkg::NRW-1:0];

      hit.hit_found    = 1'b1;
      hit.hit_distance = t_ff;
      hit.point_x      = px_ff;
      hit.point_y      = py_ff;
      hit.point_z      = pz_ff;
      hit.normal_x     = apex_ff ? '0 : nx_ff;
      hit.normal_y     = apex_ff ? '0 : ny_ff;
      hit.normal_z     = apex_ff ? rci_pkg::NORM_APEX : rci_pkg::NORM_Z;
      hit.last_result  = 1'b0;

      // closing transaction: the held hit, or an empty one
      last_rsp             = pend_valid_ff ? pend_ff : '0;
      last_rsp.last_result = 1'b1;
   end

   // ---- next state ----
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rci_pkg::BK_IDLE:    if (job_valid) state_in = rci_pkg::BK_MUL;
         rci_pkg::BK_MUL:     if (mul_cnt_ff == 3'd7) state_in = rci_pkg::BK_DISC;
         rci_pkg::BK_DISC:    state_in = disc_ok ? rci_pkg::BK_SQ_GO : rci_pkg::BK_FINISH;
         rci_pkg::BK_SQ_GO:   state_in = rci_pkg::BK_SQ_WAIT;
         rci_pkg::BK_SQ_WAIT: if (it_done) state_in = rci_pkg::BK_ROOT;
         rci_pkg::BK_ROOT:    state_in = rci_pkg::BK_DV_GO;
         rci_pkg::BK_DV_GO:   state_in = rci_pkg::BK_DV_WAIT;
         rci_pkg::BK_DV_WAIT: if (it_done) state_in = rci_pkg::BK_TEST;
         rci_pkg::BK_TEST:    state_in = reject ? rci_pkg::BK_NEXT : rci_pkg::BK_PMUL;
         rci_pkg::BK_PMUL:    state_in = rci_pkg::BK_POINT;
         rci_pkg::BK_POINT: begin
            priority if (z_bad) state_in = rci_pkg::BK_NEXT;
            else if (apex)      state_in = rci_pkg::BK_HIT;
            else                state_in = rci_pkg::BK_RMUL;
         end
         rci_pkg::BK_RMUL:    state_in = rci_pkg::BK_R_GO;
         rci_pkg::BK_R_GO:    state_in = rci_pkg::BK_R_WAIT;
         rci_pkg::BK_R_WAIT:  if (it_done) state_in = rci_pkg::BK_NX_GO;
         rci_pkg::BK_NX_GO:   state_in = rci_pkg::BK_NX_WAIT;
         rci_pkg::BK_NX_WAIT: if (it_done) state_in = rci_pkg::BK_NY_GO;
         rci_pkg::BK_NY_GO:   state_in = rci_pkg::BK_NY_WAIT;
         rci_pkg::BK_NY_WAIT: if (it_done) state_in = rci_pkg::BK_HIT;
         rci_pkg::BK_HIT:     state_in = rci_pkg::BK_NEXT;
         rci_pkg::BK_NEXT:    state_in = k_ff ? rci_pkg::BK_FINISH : rci_pkg::BK_ROOT;
         rci_pkg::BK_FINISH:  state_in = rci_pkg::BK_IDLE;
         default:             state_in = rci_pkg::BK_IDLE;
      endcase
   end

   // ---- control outputs ----
   always_comb begin
      job_pop        = (state_ff == rci_pkg::BK_IDLE) && job_valid;
      iter_req.start = 1'b0;
      iter_req.op    = rci_pkg::ITER_SQRT;
      it_rad         = disc_ff;
      it_dvd         = {num_mag_ff, {rci_pkg::FRAC_BITS{1'b0}}};
      it_dvs         = a_mag;
      unique case (state_ff)
         rci_pkg::BK_SQ_GO: iter_req.start = 1'b1;
         rci_pkg::BK_R_GO: begin
            iter_req.start = 1'b1;
            it_rad = {{(rci_pkg::RW - rci_pkg::PRW - 1){1'b0}}, sq_sum};
         end
         rci_pkg::BK_DV_GO: begin
            iter_req.start = 1'b1;
            iter_req.op    = rci_pkg::ITER_DIV;
         end
         rci_pkg::BK_NX_GO, rci_pkg::BK_NY_GO: begin
            iter_req.start = 1'b1;
            iter_req.op    = rci_pkg::ITER_DIV;
            it_dvd = {{(rci_pkg::DVW - rci_pkg::MXW){1'b0}},
                      (state_ff == rci_pkg::BK_NX_GO) ? mx_ff : my_ff};
            it_dvs = {{(rci_pkg::MW - rci_pkg::CW){1'b0}}, r_ff};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= rci_pkg::BK_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         mul_cnt_ff    <= '0;
         k_ff          <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            rci_pkg::BK_IDLE: mul_cnt_ff <= '0;
            rci_pkg::BK_MUL:  mul_cnt_ff <= mul_cnt_ff + 1'b1;
            rci_pkg::BK_DISC: k_ff <= 1'b0;
            rci_pkg::BK_NEXT: k_ff <= 1'b1;
            rci_pkg::BK_HIT: begin
               // hold the first hit until we know whether it is the final one
               rsp_valid_ff  <= pend_valid_ff;
               pend_valid_ff <= 1'b1;
            end
            rci_pkg::BK_FINISH: begin
               rsp_valid_ff  <= 1'b1;
               pend_valid_ff <= 1'b0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         rci_pkg::BK_IDLE: if (job_valid) job_ff <= job;
         rci_pkg::BK_MUL: begin
            if (mul_cnt_ff[2]) ac_ff <= acc_in;
            else               hh_ff <= acc_in;
         end
         rci_pkg::BK_DISC:    disc_ff <= disc_in;
         rci_pkg::BK_SQ_WAIT: if (it_done) s_ff <= it_res[rci_pkg::QW-1:0];
         rci_pkg::BK_ROOT: begin
            num_mag_ff <= num_abs[rci_pkg::NMW-1:0];
            neg_ff     <= num[rci_pkg::NW-1] != job_ff.a[rci_pkg::AW-1];
         end
         rci_pkg::BK_DV_WAIT: if (it_done) t_ff <= t_in;
         rci_pkg::BK_PMUL: begin
            prx_ff <= job_ff.ray.dx * $signed({1'b0, t_ff});
            pry_ff <= job_ff.ray.dy * $signed({1'b0, t_ff});
            prz_ff <= job_ff.ray.dz * $signed({1'b0, t_ff});
         end
         rci_pkg::BK_POINT: begin
            px_ff   <= px_in;
            py_ff   <= py_in;
            pz_ff   <= sumz[rci_pkg::PZW-1:0];
            apex_ff <= apex;
         end
         rci_pkg::BK_RMUL: begin
            sqx_ff <= px_ff * px_ff;
            sqy_ff <= py_ff * py_ff;
            mx_ff  <= pxa * rci_pkg::INV_SQRT2;
            my_ff  <= pya * rci_pkg::INV_SQRT2;
         end
         rci_pkg::BK_R_WAIT:  if (it_done) r_ff <= it_res[rci_pkg::CW-1:0];
         rci_pkg::BK_NX_WAIT: if (it_done) nx_ff <= px_ff[rci_pkg::CW-1] ? -q_in : q_in;
         rci_pkg::BK_NY_WAIT: if (it_done) ny_ff <= py_ff[rci_pkg::CW-1] ? -q_in : q_in;
         rci_pkg::BK_HIT: begin
            rsp_ff  <= pend_ff;
            pend_ff <= hit;
         end
         rci_pkg::BK_FINISH: rsp_ff <= last_rsp;
         default: ;
      endcase
   end

   assign rsp       = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

[rtl/ray_cone_intersect.sv]
// Top level of the ray / open cone intersection block: min_distance register,
// front end with coefficient queue, back end solver. Depends on all rci files.
//
//  channel  ports                 handshake
//  request  start, busy, req_*    taken when start is high and busy is low
//  result   rsp_valid, rsp_*      one cycle per result, no back-pressure
//  config   csr_wr_en/_wr_data    written on any edge with csr_wr_en high
//
// The front end takes a ray per cycle while its four-entry queue has room.
// The back end solves one ray at a time, going straight to the closing result
// when a is zero or the roots are not real; time is set mostly by the shared
// bit-serial square-root/divide unit (one quotient bit or root bit per cycle).
// Synchronous reset clears control state; min_distance resets to 655.
// The receiver cannot stall, so results leave as soon as they are formed.
`default_nettype none
module ray_cone_intersect (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic signed [31:0]          req_origin_x,
   input  logic signed [31:0]          req_origin_y,
   input  logic signed [31:0]          req_origin_z,
   input  logic signed [31:0]          req_dir_x,
   input  logic signed [31:0]          req_dir_y,
   input  logic signed [31:0]          req_dir_z,
   input  logic                        csr_wr_en,
   input  logic [16:0]                 csr_wr_data,
   output logic                        rsp_valid,
   output logic                        rsp_hit_found,
   output logic [30:0]                 rsp_hit_distance,
   output logic signed [31:0]          rsp_point_x,
   output logic signed [31:0]          rsp_point_y,
   output logic [16:0]                 rsp_point_z,
   output logic signed [15:0]          rsp_normal_x,
   output logic signed [15:0]          rsp_normal_y,
   output logic signed [15:0]          rsp_normal_z,
   output logic                        rsp_last_result
);

   logic [rci_pkg::MDW-1:0]  min_distance_ff;
   rci_pkg::ray_type         req_ray;
   rci_pkg::job_type         job;
   logic                     job_valid, job_pop;
   rci_pkg::result_type      rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_distance_ff <= rci_pkg::MIN_DIST_RESET;
      end else if (csr_wr_en) begin
         min_distance_ff <= csr_wr_data;
      end
   end

   always_comb begin
      req_ray.ox = req_origin_x;
      req_ray.oy = req_origin_y;
      req_ray.oz = req_origin_z;
      req_ray.dx = req_dir_x;
      req_ray.dy = req_dir_y;
      req_ray.dz = req_dir_z;
   end

   rci_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_ray   (req_ray),
      .job_pop   (job_pop),
      .job_valid (job_valid),
      .job       (job)
   );

   rci_back u_back (
      .clock        (clock),
      .reset        (reset),
      .min_distance (min_distance_ff),
      .job_valid    (job_valid),
      .job          (job),
      .job_pop      (job_pop),
      .rsp          (rsp),
      .rsp_valid    (rsp_valid)
   );

   assign rsp_hit_found    = rsp.hit_found;
   assign rsp_hit_distance = rsp.hit_distance;
   assign rsp_point_x      = rsp.point_x;
   assign rsp_point_y      = rsp.point_y;
   assign rsp_point_z      = rsp.point_z;
   assign rsp_normal_x     = rsp.normal_x;
   assign rsp_normal_y     = rsp.normal_y;
   assign rsp_normal_z     = rsp.normal_z;
   assign rsp_last_result  = rsp.last_result;

   // an empty transaction always closes its ray
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit_found |-> rsp_last_result)
      else $error("empty result not marked last");

   a_dist_min: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit_found |->
         ({14'd0, min_distance_ff} < rsp_hit_distance))
      else $error("hit closer than min_distance");

   a_z_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit_found |-> rsp_point_z <= (17'd1 << rci_pkg::FRAC_BITS))
      else $error("hit z outside cone height");

   a_apex: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit_found && rsp_normal_x == 0 && rsp_normal_y == 0 |->
         rsp_normal_z == rci_pkg::NORM_APEX)
      else $error("flat normal off the apex");

endmodule
`default_nettype wire
